// ----- rtl/core/joystick_joint_jog_limiter_defines.svh -----
// ----------------------------------------------------------------------------
// Joystick joint jog limiter assertion macros
// Shared property forms for the concurrent checks of the jog limiter.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_JOINT_JOG_LIMITER_DEFINES_SVH
`define JOYSTICK_JOINT_JOG_LIMITER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define JJJL_ASSERT_NOW(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define JJJL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/jjjl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick joint jog limiter package
// Word types, register indexes, rate constants and joint limits.
// ----------------------------------------------------------------------------
package jjjl_pkg;

  typedef struct packed {
    logic signed [15:0] axis_sideways;
    logic signed [15:0] axis_forward;
    logic signed [15:0] trigger_open;
    logic signed [15:0] axis_lift;
    logic signed [15:0] trigger_close;
    logic signed [15:0] dpad_horizontal;
    logic signed [15:0] dpad_vertical;
    logic        [3:0]  preset_buttons;
  } sample_t;

  typedef struct packed {
    logic [6:0] duty_base;
    logic [7:0] duty_shoulder;
    logic [6:0] duty_elbow;
    logic [7:0] duty_hand_tilt;
    logic [7:0] duty_wrist_turn;
    logic [7:0] duty_gripper;
  } duty_t;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctrl_t;

  localparam int AXIS_COUNT = 7;
  localparam int RATE_LANES = 7;
  localparam int JOINTS     = 6;

  localparam logic CFG_AXIS_SCALE      = 1'b0;
  localparam logic CFG_PUBLISH_DIVIDER = 1'b1;

  localparam logic signed [15:0] AXIS_SCALE_RESET      = 16'sd4096;
  localparam logic        [1:0]  PUBLISH_DIVIDER_RESET = 2'd2;

  localparam int BTN_A = 0;
  localparam int BTN_B = 1;
  localparam int BTN_X = 2;
  localparam int BTN_Y = 3;

  // Axis lanes in word order.
  localparam int AX_SIDEWAYS = 0;
  localparam int AX_FORWARD  = 1;
  localparam int AX_OPEN     = 2;
  localparam int AX_LIFT     = 3;
  localparam int AX_CLOSE    = 4;
  localparam int AX_DPAD_H   = 5;
  localparam int AX_DPAD_V   = 6;

  // Rates in Q0.16.
  localparam logic [15:0] RATE_0P1  = 16'd6554;
  localparam logic [15:0] RATE_0P03 = 16'd1966;
  localparam logic [15:0] RATE_0P06 = 16'd3932;
  localparam logic [15:0] RATE_0P4  = 16'd26214;
  localparam logic [15:0] RATE_0P5  = 16'd32768;

  // Rate lanes: source axis and rate of each scaled term.
  localparam int RL_FWD_10  = 0;
  localparam int RL_FWD_03  = 1;
  localparam int RL_SIDE_06 = 2;
  localparam int RL_DPV_40  = 3;
  localparam int RL_DPH_50  = 4;
  localparam int RL_LIFT_10 = 5;
  localparam int RL_LIFT_03 = 6;

  localparam int RATE_SRC [RATE_LANES] = '{
    AX_FORWARD, AX_FORWARD, AX_SIDEWAYS, AX_DPAD_V, AX_DPAD_H, AX_LIFT, AX_LIFT
  };
  localparam logic [15:0] RATE_VAL [RATE_LANES] = '{
    RATE_0P1, RATE_0P03, RATE_0P06, RATE_0P4, RATE_0P5, RATE_0P1, RATE_0P03
  };

  localparam int JOINT_MIN   [JOINTS] = '{50, 57, 52, 95, 65, 30};
  localparam int JOINT_MAX   [JOINTS] = '{120, 140, 115, 135, 160, 160};
  localparam int JOINT_RESET [JOINTS] = '{100, 100, 100, 90, 100, 100};

  localparam int REACH_J1_FLOOR = 57;
  localparam int REACH_J1_CEIL  = 140;
  localparam int REACH_J2_FLOOR = 52;
  localparam int REACH_J2_CEIL  = 115;

  localparam int PRESET_HOME   = 100;
  localparam int PRESET_X_J1   = 140;
  localparam int PRESET_X_J2   = 115;
  localparam int PRESET_X_J3   = 135;
  localparam int PRESET_Y_J0   = 100;
  localparam int PRESET_Y_J1   = 140;
  localparam int PRESET_Y_J2   = 57;
  localparam int PRESET_Y_J3   = 52;
  localparam int PRESET_Y_J4   = 90;

endpackage

// ----- rtl/core/jjjl_axis_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jog limiter axis multiplier
// Bit-serial signed multiply of the gain by one axis, one axis bit per cycle,
// while step is high, keeping the full product in a shift register.
// ----------------------------------------------------------------------------
module jjjl_axis_mul (
  input  logic                clk,
  input  jjjl_pkg::lane_ctrl_t ctrl,
  input  logic                last,
  input  logic signed [15:0]  gain,
  input  logic signed [15:0]  axis,
  output logic signed [31:0]  product
);

  logic signed [16:0] hi;
  logic        [15:0] lo;
  logic signed [17:0] addend;
  logic signed [17:0] sum;

  // The sign bit of the axis carries negative weight.
  always_comb begin
    addend = '0;
    if (lo[0]) begin
      addend = last ? -18'(gain) : 18'(gain);
    end
    sum = 18'(hi) + addend;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      hi <= '0;
      lo <= axis;
    end else if (ctrl.step) begin
      hi <= sum[17:1];
      lo <= {sum[0], lo[15:1]};
    end
  end

  assign product = {hi[15:0], lo};

endmodule

// ----- rtl/core/jjjl_rate_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jog limiter rate multiplier
// Bit-serial multiply of a product by an unsigned Q0.16 rate, one rate bit per
// cycle while step is high, flooring the result in the product's format.
// ----------------------------------------------------------------------------
module jjjl_rate_mul (
  input  logic                clk,
  input  jjjl_pkg::lane_ctrl_t ctrl,
  input  logic        [15:0]  rate,
  input  logic signed [31:0]  operand,
  output logic signed [31:0]  term
);

  logic signed [32:0] acc;
  logic        [15:0] rsh;
  logic signed [33:0] sum;

  always_comb begin
    sum = 34'(acc) + (rsh[0] ? 34'(operand) : 34'sd0);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= '0;
      rsh <= rate;
    end else if (ctrl.step) begin
      acc <= sum[33:1];
      rsh <= {1'b0, rsh[15:1]};
    end
  end

  assign term = acc[31:0];

endmodule

// ----- rtl/core/joystick_joint_jog_limiter.sv -----
`timescale 1ns / 1ps
// duty_valid is registered and rises when S_UPD commits an update that the
// publish divider lets through. A new sample word is taken only in S_IDLE,
// after the bit-serial gain and rate multipliers run and the update commits.
// A full duty register that is not taken holds the joint update in place.
// Reset (synchronous, active high) restores the home joint positions,
// clears the skip counter and loads the register reset values.
// ----------------------------------------------------------------------------
// Joystick joint jog limiter
// Integrates scaled joystick axes into six clamped joint positions, applies
// the reach guard and button presets, and publishes duty bytes.
// ----------------------------------------------------------------------------
`include "joystick_joint_jog_limiter_defines.svh"

module joystick_joint_jog_limiter #(
  parameter int POSITION_FRACTION_BITS = 8,
  parameter int JOINT_COUNT            = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  jjjl_pkg::sample_t sample,
  output logic              duty_valid,
  input  logic              duty_ready,
  output jjjl_pkg::duty_t   duty,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);

  import jjjl_pkg::*;

  localparam int F   = POSITION_FRACTION_BITS;
  localparam int PW  = F + 10;
  localparam int TSH = 26 - F;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_RATE = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  localparam logic [3:0] STEP_LAST = 4'd15;

  function automatic logic signed [PW-1:0] fix(input int units);
    return PW'(units <<< F);
  endfunction

  function automatic logic signed [PW-1:0] to_pos(input logic signed [31:0] v);
    logic signed [31:0] sh;
    sh = v >>> TSH;
    return sh[PW-1:0];
  endfunction

  logic [2:0]              state;
  logic [3:0]              cnt;
  logic signed [15:0]      axis_scale;
  logic [1:0]              publish_div;
  logic [1:0]              skip_cnt;
  logic [3:0]              btn;
  logic                    blocked;
  logic signed [PW-1:0]    joint_pos [JOINT_COUNT];
  logic signed [PW-1:0]    sum_pos   [JOINT_COUNT];
  logic signed [PW-1:0]    sum_next  [JOINT_COUNT];
  logic signed [PW-1:0]    pre_pos   [JOINT_COUNT];
  logic signed [PW-1:0]    new_pos   [JOINT_COUNT];
  logic signed [15:0]      axis      [AXIS_COUNT];
  logic signed [31:0]      prod      [AXIS_COUNT];
  logic signed [31:0]      term      [RATE_LANES];
  logic signed [PW-1:0]    t         [RATE_LANES];
  logic signed [PW-1:0]    fwd10;
  logic signed [PW-1:0]    fwd03;
  logic                    accept;
  logic                    emit;
  logic                    commit;
  logic                    d_pos;
  logic                    d_neg;
  logic                    blocked_next;
  lane_ctrl_t              mul_ctrl;
  lane_ctrl_t              rate_ctrl;

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign emit         = (skip_cnt >= publish_div);
  assign commit       = (state == S_UPD) && (!emit || !duty_valid || duty_ready);

  assign axis[AX_SIDEWAYS] = sample.axis_sideways;
  assign axis[AX_FORWARD]  = sample.axis_forward;
  assign axis[AX_OPEN]     = sample.trigger_open;
  assign axis[AX_LIFT]     = sample.axis_lift;
  assign axis[AX_CLOSE]    = sample.trigger_close;
  assign axis[AX_DPAD_H]   = sample.dpad_horizontal;
  assign axis[AX_DPAD_V]   = sample.dpad_vertical;

  assign mul_ctrl.load  = accept;
  assign mul_ctrl.step  = (state == S_MUL);
  assign rate_ctrl.load = accept;
  assign rate_ctrl.step = (state == S_RATE);

  for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_axis
    jjjl_axis_mul u_mul (
      .clk     (clk),
      .ctrl    (mul_ctrl),
      .last    (cnt == STEP_LAST),
      .gain    (axis_scale),
      .axis    (axis[g]),
      .product (prod[g])
    );
  end

  for (genvar g = 0; g < RATE_LANES; g++) begin : g_rate
    jjjl_rate_mul u_rate (
      .clk     (clk),
      .ctrl    (rate_ctrl),
      .rate    (RATE_VAL[g]),
      .operand (prod[RATE_SRC[g]]),
      .term    (term[g])
    );
    assign t[g] = to_pos(term[g]);
  end

  // Reach guard on the positions held before this sample.
  always_comb begin
    d_pos = (axis_scale != '0) && (sample.axis_forward != '0) &&
            (axis_scale[15] == sample.axis_forward[15]);
    d_neg = (axis_scale != '0) && (sample.axis_forward != '0) &&
            (axis_scale[15] != sample.axis_forward[15]);
    blocked_next = (joint_pos[1] <= fix(REACH_J1_FLOOR) && d_pos) ||
                   (joint_pos[1] >= fix(REACH_J1_CEIL) && d_neg) ||
                   (joint_pos[2] <= fix(REACH_J2_FLOOR) && d_pos) ||
                   (joint_pos[2] >= fix(REACH_J2_CEIL) && d_neg);
  end

  always_comb begin
    fwd10 = blocked ? '0 : t[RL_FWD_10];
    fwd03 = blocked ? '0 : t[RL_FWD_03];
    sum_next[0] = joint_pos[0] - t[RL_SIDE_06];
    sum_next[1] = joint_pos[1] - fwd10 + t[RL_LIFT_10];
    sum_next[2] = joint_pos[2] + fwd10 + t[RL_LIFT_10];
    sum_next[3] = joint_pos[3] + fwd03 - t[RL_DPV_40] - t[RL_LIFT_03];
    sum_next[4] = joint_pos[4] - t[RL_DPH_50];
    // The trigger offsets of one unit cancel each other.
    sum_next[5] = joint_pos[5] + to_pos(prod[AX_OPEN]) - to_pos(prod[AX_CLOSE]);
  end

  always_comb begin
    pre_pos = sum_pos;
    if (axis_scale != '0) begin
      if (btn[BTN_A]) begin
        pre_pos[0] = fix(PRESET_HOME);
        pre_pos[1] = fix(PRESET_HOME);
        pre_pos[2] = fix(PRESET_HOME);
        pre_pos[3] = fix(PRESET_HOME);
      end else if (btn[BTN_B]) begin
        // The B button only masks the X and Y presets.
        pre_pos = sum_pos;
      end else if (btn[BTN_X]) begin
        pre_pos[1] = fix(PRESET_X_J1);
        pre_pos[2] = fix(PRESET_X_J2);
        pre_pos[3] = fix(PRESET_X_J3);
      end else if (btn[BTN_Y]) begin
        pre_pos[0] = fix(PRESET_Y_J0);
        pre_pos[1] = fix(PRESET_Y_J1);
        pre_pos[2] = fix(PRESET_Y_J2);
        pre_pos[3] = fix(PRESET_Y_J3);
        pre_pos[4] = fix(PRESET_Y_J4);
      end
    end
    for (int k = 0; k < JOINT_COUNT; k++) begin
      if (pre_pos[k] < fix(JOINT_MIN[k])) begin
        new_pos[k] = fix(JOINT_MIN[k]);
      end else if (pre_pos[k] > fix(JOINT_MAX[k])) begin
        new_pos[k] = fix(JOINT_MAX[k]);
      end else begin
        new_pos[k] = pre_pos[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_scale  <= AXIS_SCALE_RESET;
      publish_div <= PUBLISH_DIVIDER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AXIS_SCALE: begin
          axis_scale <= cfg_data;
        end
        CFG_PUBLISH_DIVIDER: begin
          publish_div <= cfg_data[1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_MUL;
            cnt   <= '0;
          end
        end
        S_MUL: begin
          cnt <= cnt + 4'd1;
          if (cnt == STEP_LAST) begin
            state <= S_RATE;
          end
        end
        S_RATE: begin
          cnt <= cnt + 4'd1;
          if (cnt == STEP_LAST) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      btn     <= sample.preset_buttons;
      blocked <= blocked_next;
    end
    if (state == S_SUM) begin
      sum_pos <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_cnt <= '0;
      for (int k = 0; k < JOINT_COUNT; k++) begin
        joint_pos[k] <= fix(JOINT_RESET[k]);
      end
    end else if (commit) begin
      joint_pos <= new_pos;
      skip_cnt  <= emit ? 2'd0 : skip_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_valid <= 1'b0;
    end else if (commit && emit) begin
      duty_valid <= 1'b1;
    end else if (duty_ready) begin
      duty_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && emit) begin
      duty.duty_base       <= new_pos[0][F+6:F];
      duty.duty_shoulder   <= new_pos[1][F+7:F];
      duty.duty_elbow      <= new_pos[2][F+6:F];
      duty.duty_hand_tilt  <= new_pos[3][F+7:F];
      duty.duty_wrist_turn <= new_pos[4][F+7:F];
      duty.duty_gripper    <= new_pos[5][F+7:F];
    end
  end

  `JJJL_ASSERT_NEXT(a_accept_starts, clk, rst, accept, state == S_MUL, "accepted word did not start the multiply")
  `JJJL_ASSERT_NEXT(a_stall_holds, clk, rst, state == S_UPD && emit && duty_valid && !duty_ready, state == S_UPD && $stable(joint_pos[5]), "joint update passed a full duty register")
  `JJJL_ASSERT_NOW(a_grip_range, clk, rst, joint_pos[5] >= fix(JOINT_MIN[5]) && joint_pos[5] <= fix(JOINT_MAX[5]), "gripper position left its range")

endmodule

// ----- tb/tb_joystick_joint_jog_limiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick joint jog limiter testbench
// Sends joystick sample words through the valid/ready input channel and
// checks every duty word against a cycle-free model of the joint integrator.
// The run starts with directed samples at the extremes, the reach guard,
// the button presets and zero gain, then goes through random phases with
// biased stick motion, random gain and publish divider settings, and random
// bursts of idling on both channels.
// ----------------------------------------------------------------------------
module tb_joystick_joint_jog_limiter;
  import jjjl_pkg::*;

  localparam int FRAC           = 8;
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 520;

  localparam int FULL   = 16384;
  localparam int AX_MAX = 32767;
  localparam int AX_MIN = -32768;

  localparam longint Q16_TENTH = 6554;
  localparam longint Q16_3PCT  = 1966;
  localparam longint Q16_6PCT  = 3932;
  localparam longint Q16_40PCT = 26214;
  localparam longint Q16_HALF  = 32768;

  localparam int LIMIT_LO [6] = '{50, 57, 52, 95, 65, 30};
  localparam int LIMIT_HI [6] = '{120, 140, 115, 135, 160, 160};
  localparam int HOME     [6] = '{100, 100, 100, 90, 100, 100};

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  sample_t     sample       = '0;
  logic        duty_valid;
  logic        duty_ready   = 1'b0;
  duty_t       duty;
  logic        cfg_we       = 1'b0;
  logic        cfg_index    = CFG_AXIS_SCALE;
  logic [15:0] cfg_data     = '0;

  joystick_joint_jog_limiter dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .duty_valid   (duty_valid),
    .duty_ready   (duty_ready),
    .duty         (duty),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_t sample_backlog [$];
  duty_t   duty_expect    [$];
  int      errors          = 0;
  int      send_gap_pct    = 0;
  int      ready_stall_pct = 0;
  bit      calm            = 1'b0;
  int      lean [7];

  longint  joint_pos [6];
  int      skip_count;
  longint  gain;
  int      divider;

  function automatic void queue_sample(input sample_t s);
    sample_backlog.insert(sample_backlog.size(), s);
  endfunction

  function automatic longint fx(input int units);
    return longint'(units) <<< FRAC;
  endfunction

  function automatic longint rated_step(input longint d, input longint rate);
    return (d * rate) >>> (42 - FRAC);
  endfunction

  function automatic longint trigger_step(input longint d);
    return d >>> (26 - FRAC);
  endfunction

  function automatic bit advance_joints(input sample_t s, output duty_t res);
    longint     d;
    logic [3:0] btn;
    bit         held;
    res = '0;
    btn = s.preset_buttons;

    d = gain * longint'($signed(s.axis_forward));
    held = (joint_pos[1] <= fx(LIMIT_LO[1]) && d > 0) ||
           (joint_pos[1] >= fx(LIMIT_HI[1]) && d < 0) ||
           (joint_pos[2] <= fx(LIMIT_LO[2]) && d > 0) ||
           (joint_pos[2] >= fx(LIMIT_HI[2]) && d < 0);
    if (!held) begin
      joint_pos[1] -= rated_step(d, Q16_TENTH);
      joint_pos[2] += rated_step(d, Q16_TENTH);
      joint_pos[3] += rated_step(d, Q16_3PCT);
    end

    d = gain * longint'($signed(s.axis_sideways));
    joint_pos[0] -= rated_step(d, Q16_6PCT);
    d = gain * longint'($signed(s.dpad_vertical));
    joint_pos[3] -= rated_step(d, Q16_40PCT);
    d = gain * longint'($signed(s.dpad_horizontal));
    joint_pos[4] -= rated_step(d, Q16_HALF);

    d = gain * longint'($signed(s.axis_lift));
    joint_pos[1] += rated_step(d, Q16_TENTH);
    joint_pos[2] += rated_step(d, Q16_TENTH);
    joint_pos[3] -= rated_step(d, Q16_3PCT);

    joint_pos[5] += trigger_step(gain * longint'($signed(s.trigger_open))) - fx(1);
    joint_pos[5] -= trigger_step(gain * longint'($signed(s.trigger_close))) - fx(1);

    if (gain != 0) begin
      if (btn[BTN_A]) begin
        joint_pos[0] = fx(100);
        joint_pos[1] = fx(100);
        joint_pos[2] = fx(100);
        joint_pos[3] = fx(100);
      end else if (btn[BTN_B]) begin
        // B leaves the joints alone and only masks X and Y.
      end else if (btn[BTN_X]) begin
        joint_pos[1] = fx(140);
        joint_pos[2] = fx(115);
        joint_pos[3] = fx(135);
      end else if (btn[BTN_Y]) begin
        joint_pos[0] = fx(100);
        joint_pos[1] = fx(140);
        joint_pos[2] = fx(57);
        joint_pos[3] = fx(52);
        joint_pos[4] = fx(90);
      end
    end

    for (int k = 0; k < 6; k++) begin
      if (joint_pos[k] < fx(LIMIT_LO[k])) joint_pos[k] = fx(LIMIT_LO[k]);
      else if (joint_pos[k] > fx(LIMIT_HI[k])) joint_pos[k] = fx(LIMIT_HI[k]);
    end

    if (skip_count < divider) begin
      skip_count = (skip_count + 1) & 3;
      return 1'b0;
    end
    skip_count = 0;
    res.duty_base       = 7'(joint_pos[0] >>> FRAC);
    res.duty_shoulder   = 8'(joint_pos[1] >>> FRAC);
    res.duty_elbow      = 7'(joint_pos[2] >>> FRAC);
    res.duty_hand_tilt  = 8'(joint_pos[3] >>> FRAC);
    res.duty_wrist_turn = 8'(joint_pos[4] >>> FRAC);
    res.duty_gripper    = 8'(joint_pos[5] >>> FRAC);
    return 1'b1;
  endfunction

  // Sample word driver.
  always @(posedge clk) begin
    static int gap_left = 0;
    duty_t     res;
    if (rst) begin
      sample_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (sample_valid && sample_ready) begin
        if (advance_joints(sample, res)) duty_expect.insert(duty_expect.size(), res);
      end
      if (!sample_valid || sample_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          sample_valid <= 1'b0;
        end else if (sample_backlog.size() != 0) begin
          sample       <= sample_backlog.pop_front();
          sample_valid <= 1'b1;
          if (!calm && $urandom_range(0, 99) < send_gap_pct)
            gap_left = $urandom_range(1, 13);
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_byte(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Duty word monitor.
  always @(posedge clk) begin
    static int stall_left = 0;
    duty_t     want;
    if (rst) begin
      duty_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (duty_valid && duty_ready) begin
        if (duty_expect.size() == 0) begin
          $display("%0t: duty word expected none actual %h", $time, duty);
          errors++;
        end else begin
          want = duty_expect.pop_front();
          compare_byte("duty_base", int'(want.duty_base), int'(duty.duty_base));
          compare_byte("duty_shoulder", int'(want.duty_shoulder),
                       int'(duty.duty_shoulder));
          compare_byte("duty_elbow", int'(want.duty_elbow), int'(duty.duty_elbow));
          compare_byte("duty_hand_tilt", int'(want.duty_hand_tilt),
                       int'(duty.duty_hand_tilt));
          compare_byte("duty_wrist_turn", int'(want.duty_wrist_turn),
                       int'(duty.duty_wrist_turn));
          compare_byte("duty_gripper", int'(want.duty_gripper),
                       int'(duty.duty_gripper));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        duty_ready <= 1'b0;
      end else begin
        duty_ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < ready_stall_pct)
          stall_left = $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk) begin
    static int quiet = 0;
    if (rst || (sample_valid && sample_ready) || (duty_valid && duty_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_AXIS_SCALE) gain = longint'($signed(val));
    else divider = int'(val[1:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || sample_valid || duty_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic start_phase(input logic [15:0] scale, input logic [1:0] div,
                             input int gap_pct, input int stall_pct);
    drain();
    write_reg(CFG_AXIS_SCALE, scale);
    write_reg(CFG_PUBLISH_DIVIDER, {14'd0, div});
    @(negedge clk);
    send_gap_pct    = gap_pct;
    ready_stall_pct = stall_pct;
    for (int i = 0; i < 7; i++) lean[i] = int'($urandom_range(0, 2)) - 1;
  endtask

  function automatic sample_t make_sample(input int side, input int fwd, input int open,
                                          input int lift, input int close, input int dph,
                                          input int dpv, input int btn);
    sample_t s;
    s.axis_sideways   = 16'(side);
    s.axis_forward    = 16'(fwd);
    s.trigger_open    = 16'(open);
    s.axis_lift       = 16'(lift);
    s.trigger_close   = 16'(close);
    s.dpad_horizontal = 16'(dph);
    s.dpad_vertical   = 16'(dpv);
    s.preset_buttons  = 4'(btn);
    return s;
  endfunction

  function automatic logic [15:0] pick_axis(input int dir);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'($urandom);
    if (r < 14) begin
      case ($urandom_range(0, 4))
        0:       return 16'(AX_MIN);
        1:       return 16'(AX_MAX);
        2:       return 16'(-FULL);
        3:       return 16'(FULL);
        default: return 16'd0;
      endcase
    end
    if (dir == 0) return 16'(int'($urandom_range(0, 2 * FULL)) - FULL);
    return 16'(dir * int'($urandom_range(4096, FULL)));
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.axis_sideways   = pick_axis(lean[0]);
    s.axis_forward    = pick_axis(lean[1]);
    s.trigger_open    = pick_axis(lean[2]);
    s.axis_lift       = pick_axis(lean[3]);
    s.trigger_close   = pick_axis(lean[4]);
    s.dpad_horizontal = pick_axis(lean[5]);
    s.dpad_vertical   = pick_axis(lean[6]);
    s.preset_buttons  = ($urandom_range(0, 99) < 85) ? 4'd0 : 4'($urandom_range(0, 15));
    return s;
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'd4096;
      3:       return 16'h0000;
      4:       return 16'(-4096);
      5, 6:    return 16'($urandom);
      default: return 16'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(16384, 32767)));
    endcase
  endfunction

  function automatic int pick_pct(input int a, input int b, input int c);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return a;
      2:       return b;
      default: return c;
    endcase
  endfunction

  initial begin
    int placed;
    int n;
    for (int k = 0; k < 6; k++) joint_pos[k] = fx(HOME[k]);
    skip_count = 0;
    gain       = 4096;
    divider    = 2;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Extremes of every axis and several button combinations at unit gain.
    start_phase(16'd4096, 2'd0, 0, 0);
    queue_sample(make_sample(0, 0, FULL, 0, FULL, 0, 0, 0));
    queue_sample(make_sample(FULL, FULL, -FULL, FULL, -FULL, FULL, FULL, 0));
    queue_sample(make_sample(-FULL, -FULL, FULL, -FULL, FULL, -FULL, -FULL, 0));
    queue_sample(make_sample(AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX,
                             AX_MAX, 0));
    queue_sample(make_sample(AX_MIN, AX_MIN, AX_MIN, AX_MIN, AX_MIN, AX_MIN,
                             AX_MIN, 0));
    queue_sample(make_sample(4000, -3000, FULL, 2000, FULL, -5000, 6000, 1));
    queue_sample(make_sample(4000, -3000, FULL, 2000, FULL, -5000, 6000, 2));
    queue_sample(make_sample(4000, -3000, FULL, 2000, FULL, -5000, 6000, 4));
    queue_sample(make_sample(4000, -3000, FULL, 2000, FULL, -5000, 6000, 8));
    queue_sample(make_sample(-4000, 3000, FULL, -2000, FULL, 5000, -6000, 3));
    queue_sample(make_sample(-4000, 3000, FULL, -2000, FULL, 5000, -6000, 6));
    queue_sample(make_sample(-4000, 3000, FULL, -2000, FULL, 5000, -6000, 12));
    queue_sample(make_sample(-4000, 3000, FULL, -2000, FULL, 5000, -6000, 15));

    // Reach guard at the elbow floor and at the shoulder ceiling, full gain.
    start_phase(16'h7fff, 2'd0, 20, 20);
    queue_sample(make_sample(0, 0, FULL, 0, FULL, 0, 0, 8));
    repeat (4) queue_sample(make_sample(0, 0, FULL, AX_MIN, FULL, 0, 0, 0));
    queue_sample(make_sample(0, AX_MAX, FULL, 0, FULL, 0, 0, 0));
    queue_sample(make_sample(0, 0, FULL, 0, FULL, 0, 0, 4));
    queue_sample(make_sample(0, AX_MIN, FULL, 0, FULL, 0, 0, 0));
    queue_sample(make_sample(0, 0, AX_MIN, 0, AX_MAX, 0, 0, 0));

    // Zero gain with presets pressed; the skip counter is left at three.
    start_phase(16'h0000, 2'd3, 0, 0);
    queue_sample(make_sample(AX_MAX, AX_MAX, 0, AX_MAX, 0, AX_MAX, AX_MAX, 1));
    queue_sample(make_sample(AX_MIN, AX_MIN, 0, AX_MIN, 0, AX_MIN, AX_MIN, 4));
    queue_sample(make_sample(FULL, -FULL, 0, FULL, 0, -FULL, FULL, 8));

    // A smaller divider than the held count emits on the next sample.
    start_phase(16'h8000, 2'd0, 10, 10);
    placed = 0;
    n = 20;
    while (placed < RANDOM_ITEMS) begin
      for (int i = 0; i < n; i++) queue_sample(random_sample());
      placed += n;
      start_phase(pick_scale(), 2'($urandom_range(0, 3)), pick_pct(10, 35, 70),
                  pick_pct(3, 10, 30));
      n = $urandom_range(15, 50);
    end
    calm = 1'b1;
    send_gap_pct    = 0;
    ready_stall_pct = 0;
    for (int i = 0; i < 40; i++) queue_sample(random_sample());

    drain();
    if (duty_expect.size() != 0) begin
      $display("%0t: %0d duty words expected, actual none", $time, duty_expect.size());
      errors++;
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
